// ----- src/lfb_pkg.sv -----
package lfb_pkg;

    // Longest run of text bytes in one frame.
    localparam int MAX_FRAME_DATA = 239;
    localparam int CNT_W          = $clog2(MAX_FRAME_DATA + 1);

    // Depth of the job queue between the front and the back.
    localparam int JQ_DEPTH = 4;
    localparam int JQ_PTR_W = $clog2(JQ_DEPTH);
    localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);

    // Link control characters.
    localparam logic [7:0] CH_STX  = 8'h02;
    localparam logic [7:0] CH_ETX  = 8'h03;
    localparam logic [7:0] CH_ETB  = 8'h17;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_A    = 8'h41;

    // Positions of the output words within a full frame sequence.
    localparam int POS_W = 4;
    localparam logic [POS_W-1:0] POS_STX  = 4'd0;
    localparam logic [POS_W-1:0] POS_DIG  = 4'd1;
    localparam logic [POS_W-1:0] POS_DATA = 4'd2;
    localparam logic [POS_W-1:0] POS_CR1  = 4'd3;
    localparam logic [POS_W-1:0] POS_TERM = 4'd4;
    localparam logic [POS_W-1:0] POS_HEXH = 4'd5;
    localparam logic [POS_W-1:0] POS_HEXL = 4'd6;
    localparam logic [POS_W-1:0] POS_CR2  = 4'd7;
    localparam logic [POS_W-1:0] POS_LF   = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       run_last;
        logic       frame_end;
    } out_word_t;

    // One classified input word, ready for the back to expand.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] digit;
        logic       open_frame;
        logic       close_frame;
        logic       last_frame;
        logic [7:0] checksum;
    } job_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10)
        begin
            res = CH_ZERO + {4'd0, nib};
        end
        else
        begin
            res = CH_A + {4'd0, nib} - 8'd10;
        end
        return res;
    endfunction

endpackage

// ----- src/lfb_front.sv -----
module lfb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lfb_pkg::in_word_t in_word,
    input  logic          jq_full,
    output logic          accept,
    output lfb_pkg::job_t job
);
    import lfb_pkg::*;

    logic [2:0]       digit_reg, digit_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;

    logic             open_frame;
    logic             close_frame;
    logic [7:0]       base_sum;
    logic [7:0]       sum_data;
    logic [CNT_W:0]   count_inc;
    logic [7:0]       term;

    always_comb
    begin
        accept      = push && !jq_full;
        open_frame  = (count_reg == '0);
        base_sum    = open_frame ? (CH_ZERO + {5'd0, digit_reg}) : sum_reg;
        sum_data    = base_sum + in_word.data_byte;
        count_inc   = {1'b0, count_reg} + {{CNT_W{1'b0}}, 1'b1};
        close_frame = in_word.message_last ||
                      (count_inc >= (CNT_W + 1)'(MAX_FRAME_DATA));
        term        = in_word.message_last ? CH_ETX : CH_ETB;

        job.data_byte   = in_word.data_byte;
        job.digit       = digit_reg;
        job.open_frame  = open_frame;
        job.close_frame = close_frame;
        job.last_frame  = in_word.message_last;
        job.checksum    = sum_data + CH_CR + term;

        digit_next = digit_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        if (accept)
        begin
            if (close_frame)
            begin
                digit_next = digit_reg + 3'd1;
                count_next = '0;
                sum_next   = '0;
            end
            else
            begin
                count_next = count_inc[CNT_W-1:0];
                sum_next   = sum_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 3'd1;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

`ifndef ASSERT_OFF
    // The open frame never holds a full load of text without being closed.
    a_count_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(MAX_FRAME_DATA))
        else $error("frame byte count reached the limit without a close");
`endif

endmodule

// ----- src/lfb_job_queue.sv -----
module lfb_job_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  lfb_pkg::job_t wr_job,
    output logic          full,
    input  logic          rd_en,
    output lfb_pkg::job_t rd_job,
    output logic          empty
);
    import lfb_pkg::*;

    job_t                slot_reg [JQ_DEPTH];
    logic [JQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JQ_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        full   = (cnt_reg == JQ_CNT_W'(JQ_DEPTH));
        empty  = (cnt_reg == '0);
        rd_job = slot_reg[rd_ptr_reg];

        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && empty))
        else $error("job queue read while empty");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("job queue written while full");
`endif

endmodule

// ----- src/lfb_back.sv -----
module lfb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lfb_pkg::job_t     job,
    input  logic              jq_empty,
    output logic              jq_pop,
    input  logic              pop,
    output logic              empty,
    output lfb_pkg::out_word_t out_word
);
    import lfb_pkg::*;

    logic             active_reg, active_next;
    logic [POS_W-1:0] step_reg, step_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_reg, out_next;

    logic             adv;
    logic [POS_W-1:0] pos;
    logic             job_done;
    logic [7:0]       byte_sel;

    always_comb
    begin
        adv = !jq_empty && (!out_valid_reg || pop);
        if (active_reg)
        begin
            pos = step_reg;
        end
        else
        begin
            pos = job.open_frame ? POS_STX : POS_DATA;
        end

        case (pos)
            POS_STX:  byte_sel = CH_STX;
            POS_DIG:  byte_sel = CH_ZERO + {5'd0, job.digit};
            POS_DATA: byte_sel = job.data_byte;
            POS_CR1:  byte_sel = CH_CR;
            POS_TERM: byte_sel = job.last_frame ? CH_ETX : CH_ETB;
            POS_HEXH: byte_sel = hex_char(job.checksum[7:4]);
            POS_HEXL: byte_sel = hex_char(job.checksum[3:0]);
            POS_CR2:  byte_sel = CH_CR;
            POS_LF:   byte_sel = CH_LF;
            default:  byte_sel = 8'h00;
        endcase

        job_done = ((pos == POS_DATA) && !job.close_frame) || (pos == POS_LF);
        jq_pop   = adv && job_done;

        active_next = active_reg;
        step_next   = step_reg;
        if (adv)
        begin
            active_next = !job_done;
            step_next   = pos + 1'b1;
        end

        out_next = out_reg;
        if (adv)
        begin
            out_next.frame_byte = byte_sel;
            out_next.run_last   = job_done;
            out_next.frame_end  = (pos == POS_LF);
        end

        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        empty    = !out_valid_reg;
        out_word = out_reg;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    // A frame's closing LF always ends the run of the word that caused it.
    a_lf_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.frame_end) |->
            (out_reg.run_last && out_reg.frame_byte == CH_LF))
        else $error("frame end flagged on a word that does not close the run");

    // While a job is in progress it stays at the head of the queue.
    a_active_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> !jq_empty)
        else $error("sequencer active with no job queued");
`endif

endmodule

// ----- src/lab_link_frame_builder_top.sv -----
// An accepted input word is written into the job queue; with the back idle and the output
// slot free, its first result word then goes into the output register. Throughput: one
// result word per cycle while the output slot is free or popped; an input word that yields
// n result words holds the back until all n are sent, and input is taken every cycle while
// the four-entry job queue has room. Reset (rst_n, asynchronous, active low) empties the job
// queue and output slot, sets the frame digit to 1 and clears the frame byte count and running checksum.
module lab_link_frame_builder_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lfb_pkg::in_word_t  in_word,
    output logic               empty,
    input  logic               pop,
    output lfb_pkg::out_word_t out_word
);
    import lfb_pkg::*;

    // The front keeps the framing state (frame digit, byte count, checksum) and turns each
    // accepted word into a job that already knows whether it opens or closes a frame and,
    // for a word that closes a frame, what the frame's final checksum is.
    logic  accept;
    job_t  front_job;

    // The queue decouples the front from the back, so that short words keep flowing in
    // while the back is busy sending a frame header or trailer.
    logic  jq_full;
    logic  jq_empty;
    logic  jq_pop;
    job_t  head_job;

    assign full = jq_full;

    lfb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_word (in_word),
        .jq_full (jq_full),
        .accept  (accept),
        .job     (front_job)
    );

    lfb_job_queue u_job_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_job (front_job),
        .full   (jq_full),
        .rd_en  (jq_pop),
        .rd_job (head_job),
        .empty  (jq_empty)
    );

    // The back walks through the header, data and trailer positions of the head job, one
    // output word per cycle while the output register is free or popped, into that register.
    lfb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (head_job),
        .jq_empty (jq_empty),
        .jq_pop   (jq_pop),
        .pop      (pop),
        .empty    (empty),
        .out_word (out_word)
    );

endmodule
